[rtl/ogp_pkg.sv]
package ogp_pkg;

    // grid geometry
    localparam int CELL_SIZE = 32;
    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 64;
    localparam int CELL2     = 2 * CELL_SIZE;

    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int CI_W  = COL_W + 1;          // column count incl. GRID_COLS
    localparam int RI_W  = ROW_W + 1;          // row count incl. GRID_ROWS

    // field widths
    localparam int CMD_W      = 3;
    localparam int MM_W       = 16;
    localparam int RAD_W      = 12;
    localparam int R_W        = 10;            // robot radius
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // internal widths
    localparam int W_W   = 20;                 // padded mm / cell sums
    localparam int CR_W  = 13;                 // radius + robot radius
    localparam int N_W   = CR_W + 1;           // circle cell count
    localparam int OFF_W = $clog2(CELL_SIZE) + 1;
    localparam int SQ_W  = 2 * (N_W + 1);
    localparam int LH_W  = MM_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT  = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_BORDER = 3'd1,
        CMD_RECT   = 3'd2,
        CMD_CIRCLE = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD1,
        S_PAD2,
        S_CELLS,
        S_DISPATCH,
        S_ADJ,
        S_RD,
        S_WR,
        S_QRD,
        S_QDAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start_walk;
        logic clr_grid;
        logic x_dec;
        logic row_rd;
        logic row_wr;
        logic q_rd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             over;
        logic             last;
    } t_dp_sts;

    // second half of the padding: grow by radius or clamp to the area
    function automatic logic [W_W-1:0] pad_size(
        input logic [MM_W-1:0] c,
        input logic [MM_W:0]   s,
        input logic [R_W-1:0]  r,
        input logic [MM_W-1:0] lim
    );
        logic [W_W-1:0] sum;
        sum = W_W'(c) + W_W'(s) + W_W'(r);
        if (sum < W_W'(lim)) begin
            return W_W'(s) + W_W'(r);
        end else if (lim > c) begin
            return W_W'(lim - c);
        end else begin
            return '0;
        end
    endfunction

    // millimetres to cells, half up
    function automatic logic [W_W-1:0] to_cells(input logic [W_W-1:0] mm);
        logic [W_W+1:0] t;
        t = {1'b0, mm, 1'b0} + (W_W+2)'(CELL_SIZE);
        return W_W'(t / CELL2);
    endfunction

endpackage

[rtl/ogp_ram.sv]
module ogp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/ogp_ctrl.sv]
module ogp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall,
    input  ogp_pkg::t_dp_sts i_sts,
    output logic             o_stall,
    output logic             o_valid,
    output ogp_pkg::t_dp_cmd o_ctl
);
    import ogp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_PAD1;
            S_PAD1:     n_state = S_PAD2;
            S_PAD2:     n_state = S_CELLS;
            S_CELLS:    n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_QUERY:              n_state = S_QRD;
                    CMD_BORDER, CMD_RECT:   n_state = i_sts.empty ? S_OUT : S_RD;
                    CMD_CIRCLE:             n_state = i_sts.empty ? S_OUT : S_ADJ;
                    default:                n_state = S_OUT;
                endcase
            end
            S_ADJ:      if (!i_sts.over) n_state = S_RD;
            S_RD:       n_state = S_WR;
            S_WR: begin
                if (i_sts.last) begin
                    n_state = S_OUT;
                end else if (i_sts.cmd == CMD_CIRCLE) begin
                    n_state = S_ADJ;
                end else begin
                    n_state = S_RD;
                end
            end
            S_QRD:      n_state = S_QDAT;
            S_QDAT:     n_state = S_OUT;
            S_OUT:      if (!i_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE:     o_ctl.load = i_valid;
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_CLEAR: begin
                        o_ctl.clr_grid = 1'b1;
                        o_ctl.finish   = 1'b1;
                    end
                    CMD_QUERY: ;
                    CMD_BORDER, CMD_RECT, CMD_CIRCLE: begin
                        o_ctl.finish     = i_sts.empty;
                        o_ctl.start_walk = !i_sts.empty;
                    end
                    default:   o_ctl.finish = 1'b1;
                endcase
            end
            S_ADJ:      o_ctl.x_dec = i_sts.over;
            S_RD:       o_ctl.row_rd = 1'b1;
            S_WR: begin
                o_ctl.row_wr = 1'b1;
                o_ctl.finish = i_sts.last;
            end
            S_QRD:      o_ctl.q_rd = 1'b1;
            S_QDAT:     o_ctl.finish = 1'b1;
            default:    ;
        endcase
    end
endmodule

[rtl/ogp_dp.sv]
module ogp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ogp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ogp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ogp_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ogp_pkg::MM_W-1:0]       i_pos_x,
    input  logic [ogp_pkg::MM_W-1:0]       i_pos_y,
    input  logic [ogp_pkg::MM_W-1:0]       i_size_w,
    input  logic [ogp_pkg::MM_W-1:0]       i_size_h,
    input  logic [ogp_pkg::RAD_W-1:0]      i_radius,
    input  ogp_pkg::t_dp_cmd               i_ctl,
    output ogp_pkg::t_dp_sts               o_sts,
    output logic                           o_drawn,
    output logic                           o_inside_res,
    output logic                           o_obstacle,
    output logic [ogp_pkg::COL_W-1:0]      o_cell_col,
    output logic [ogp_pkg::ROW_W-1:0]      o_cell_row
);
    import ogp_pkg::*;

    // config
    logic [R_W-1:0]   r_robot_radius;
    logic [MM_W-1:0]  r_area_width;
    logic [MM_W-1:0]  r_area_height;

    // latched command
    logic [CMD_W-1:0] r_cmd;
    logic [MM_W-1:0]  r_px, r_py, r_sw, r_sh;
    logic [RAD_W-1:0] r_rad;

    // stage 1
    logic [MM_W-1:0]  r_p1_cx, r_p1_cy;
    logic [MM_W:0]    r_p1_sx, r_p1_sy;
    logic [CR_W-1:0]  r_cr;
    logic [MM_W-1:0]  r_x0, r_y0;
    logic [OFF_W-1:0] r_m;
    logic [R_W-1:0]   r_bw;
    logic [OFF_W-1:0] w_dx, w_dy, w_m;

    // stage 2
    logic [MM_W-1:0]  r_p2_cx, r_p2_cy;
    logic [W_W-1:0]   r_p2_sx, r_p2_sy;
    logic [N_W-1:0]   r_n;
    logic             r_n_pos;
    logic [CR_W:0]    w_q, w_qmag, w_qdiv;

    // stage 3
    logic [W_W-1:0]   w_c0, w_c1, w_c1c, w_r0, w_r1, w_r1c;
    logic             w_fit;
    logic [N_W:0]     w_twon1;
    logic [SQ_W-1:0]  w_rr;
    logic [SQ_W-1:0]  r_rr;
    logic [CI_W-1:0]  r_lo, r_hi, r_wc;
    logic [RI_W-1:0]  r_wr, r_row_start, r_row_end;
    logic             r_drawn;

    // walk
    logic [RI_W-1:0]  r_row;
    logic [N_W-1:0]   r_xoff, r_yoff;
    logic             r_side;
    logic [N_W:0]     w_ex2, w_ey2;
    logic [SQ_W-1:0]  w_ex, w_ey;
    logic [LH_W-1:0]  w_lo, w_hi, w_row_full;
    logic             w_full, w_bmode;
    logic [ROW_W-1:0] w_row_addr, w_raddr;
    logic [GRID_COLS-1:0] w_mask, w_wdata, w_rdata;
    logic [GRID_ROWS-1:0] r_row_vld;
    logic             r_rd_vld;

    // query
    logic             w_q_hit;

    // output word
    logic             r_o_drawn, r_o_inside, r_o_obst;
    logic [COL_W-1:0] r_o_col;
    logic [ROW_W-1:0] r_o_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_radius <= R_W'(150);
            r_area_width   <= MM_W'(3000);
            r_area_height  <= MM_W'(2000);
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                CFG_ROBOT_RADIUS: r_robot_radius <= i_cfg_data[R_W-1:0];
                CFG_AREA_WIDTH:   r_area_width   <= i_cfg_data;
                CFG_AREA_HEIGHT:  r_area_height  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_sw  <= i_size_w;
            r_sh  <= i_size_h;
            r_rad <= i_radius;
        end
    end

    // stage 1: first half of padding, circle centre cell and offset
    always_comb begin
        w_dx = OFF_W'(r_px % CELL_SIZE);
        w_dy = OFF_W'(r_py % CELL_SIZE);
        w_m  = w_dx;
        if (w_dy > w_m) w_m = w_dy;
        if (OFF_W'(CELL_SIZE) - w_dx > w_m) w_m = OFF_W'(CELL_SIZE) - w_dx;
        if (OFF_W'(CELL_SIZE) - w_dy > w_m) w_m = OFF_W'(CELL_SIZE) - w_dy;
    end

    always_ff @(posedge i_clk) begin
        if (r_px > MM_W'(r_robot_radius)) begin
            r_p1_cx <= r_px - MM_W'(r_robot_radius);
            r_p1_sx <= (MM_W+1)'(r_sw) + (MM_W+1)'(r_robot_radius);
        end else begin
            r_p1_cx <= '0;
            r_p1_sx <= (MM_W+1)'(r_sw);
        end
        if (r_py > MM_W'(r_robot_radius)) begin
            r_p1_cy <= r_py - MM_W'(r_robot_radius);
            r_p1_sy <= (MM_W+1)'(r_sh) + (MM_W+1)'(r_robot_radius);
        end else begin
            r_p1_cy <= '0;
            r_p1_sy <= (MM_W+1)'(r_sh);
        end
        r_cr <= CR_W'(r_rad) + CR_W'(r_robot_radius);
        r_x0 <= MM_W'(r_px / CELL_SIZE);
        r_y0 <= MM_W'(r_py / CELL_SIZE);
        r_m  <= w_m;
        r_bw <= R_W'(r_robot_radius / CELL_SIZE);
    end

    // stage 2: clamp padding, circle cell count (division truncates to zero)
    assign w_q    = (CR_W+1)'(r_cr) - (CR_W+1)'(r_m);
    assign w_qmag = w_q[CR_W] ? ((CR_W+1)'(0) - w_q) : w_q;
    assign w_qdiv = (CR_W+1)'(w_qmag / CELL_SIZE);

    always_ff @(posedge i_clk) begin
        r_p2_cx <= r_p1_cx;
        r_p2_cy <= r_p1_cy;
        r_p2_sx <= pad_size(r_p1_cx, r_p1_sx, r_robot_radius, r_area_width);
        r_p2_sy <= pad_size(r_p1_cy, r_p1_sy, r_robot_radius, r_area_height);
        r_n     <= w_q[CR_W] ? N_W'(1) : N_W'(w_qdiv) + N_W'(1);
        r_n_pos <= !w_q[CR_W] || (w_qdiv == '0);
    end

    // stage 3: cell ranges, fit test, radius square
    always_comb begin
        w_c0  = to_cells(W_W'(r_p2_cx));
        w_c1  = w_c0 + to_cells(r_p2_sx);
        w_c1c = (w_c1 > W_W'(GRID_COLS)) ? W_W'(GRID_COLS) : w_c1;
        w_r0  = to_cells(W_W'(r_p2_cy));
        w_r1  = w_r0 + to_cells(r_p2_sy);
        w_r1c = (w_r1 > W_W'(GRID_ROWS)) ? W_W'(GRID_ROWS) : w_r1;
        w_fit = (W_W'(r_x0) + W_W'(1) >= W_W'(r_n))
             && (W_W'(r_x0) + W_W'(r_n) <= W_W'(GRID_COLS))
             && (W_W'(r_y0) + W_W'(1) >= W_W'(r_n))
             && (W_W'(r_y0) + W_W'(r_n) <= W_W'(GRID_ROWS));
    end

    assign w_twon1 = {r_n, 1'b0} - (N_W+1)'(1);
    assign w_rr    = w_twon1 * w_twon1;

    always_ff @(posedge i_clk) begin
        r_rr  <= w_rr;
        r_lo  <= CI_W'(w_c0);
        r_hi  <= CI_W'(w_c1c);
        r_wc  <= (W_W'(r_bw) > W_W'(GRID_COLS)) ? CI_W'(GRID_COLS) : CI_W'(r_bw);
        r_wr  <= (W_W'(r_bw) > W_W'(GRID_ROWS)) ? RI_W'(GRID_ROWS) : RI_W'(r_bw);
        if (r_cmd == CMD_RECT) begin
            r_row_start <= RI_W'(w_r0);
            r_row_end   <= RI_W'(w_r1c);
        end else begin
            r_row_start <= '0;
            r_row_end   <= RI_W'(GRID_ROWS);
        end
        unique case (r_cmd)
            CMD_CLEAR:  r_drawn <= 1'b1;
            CMD_BORDER: r_drawn <= (r_bw != '0);
            CMD_RECT:   r_drawn <= (w_c0 < w_c1c) && (w_r0 < w_r1c);
            CMD_CIRCLE: r_drawn <= r_n_pos && w_fit;
            default:    r_drawn <= 1'b0;
        endcase
    end

    // walk counters
    always_ff @(posedge i_clk) begin
        if (i_ctl.start_walk) begin
            r_row  <= r_row_start;
            r_xoff <= r_n - N_W'(1);
            r_yoff <= '0;
            r_side <= 1'b0;
        end else if (i_ctl.x_dec) begin
            r_xoff <= r_xoff - N_W'(1);
        end else if (i_ctl.row_wr) begin
            if (r_cmd == CMD_CIRCLE) begin
                r_side <= !r_side;
                if (r_side) r_yoff <= r_yoff + N_W'(1);
            end else begin
                r_row <= r_row + RI_W'(1);
            end
        end
    end

    // circle edge: (2X)^2 + (2Y+1)^2 against (2N-1)^2, cell size cancels
    assign w_ex2 = {r_xoff, 1'b0};
    assign w_ey2 = {r_yoff, 1'b1};
    assign w_ex  = w_ex2 * w_ex2;
    assign w_ey  = w_ey2 * w_ey2;

    always_comb begin
        w_lo       = '0;
        w_hi       = '0;
        w_full     = 1'b0;
        w_bmode    = 1'b0;
        w_row_full = LH_W'(r_row);
        if (r_cmd == CMD_CIRCLE) begin
            w_lo = LH_W'(r_x0) - LH_W'(r_xoff);
            w_hi = LH_W'(r_x0) + LH_W'(r_xoff) + LH_W'(1);
            w_row_full = r_side ? (LH_W'(r_y0) - LH_W'(r_yoff))
                                : (LH_W'(r_y0) + LH_W'(r_yoff));
        end else if (r_cmd == CMD_BORDER) begin
            w_bmode = 1'b1;
            w_full  = (r_row < r_wr) || (r_row >= RI_W'(GRID_ROWS) - r_wr);
        end else begin
            w_lo = LH_W'(r_lo);
            w_hi = LH_W'(r_hi);
        end
        for (int j = 0; j < GRID_COLS; j++) begin
            if (w_bmode) begin
                w_mask[j] = w_full || (CI_W'(j) < r_wc)
                         || (CI_W'(j) >= CI_W'(GRID_COLS) - r_wc);
            end else begin
                w_mask[j] = (LH_W'(j) >= w_lo) && (LH_W'(j) < w_hi);
            end
        end
    end

    assign w_row_addr = w_row_full[ROW_W-1:0];
    assign w_raddr    = i_ctl.q_rd ? r_y0[ROW_W-1:0] : w_row_addr;
    assign w_wdata    = (r_rd_vld ? w_rdata : '0) | w_mask;

    ogp_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (i_ctl.row_wr),
        .i_waddr (w_row_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // row valid bits: a clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_ctl.clr_grid) begin
            r_row_vld <= '0;
        end else if (i_ctl.row_wr) begin
            r_row_vld[w_row_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[w_raddr];
    end

    assign w_q_hit = (r_cmd == CMD_QUERY)
                  && (r_x0 < MM_W'(GRID_COLS)) && (r_y0 < MM_W'(GRID_ROWS));

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_o_drawn  <= r_drawn;
            r_o_inside <= w_q_hit;
            r_o_obst   <= w_q_hit && r_rd_vld && w_rdata[r_x0[COL_W-1:0]];
            r_o_col    <= w_q_hit ? r_x0[COL_W-1:0] : '0;
            r_o_row    <= w_q_hit ? r_y0[ROW_W-1:0] : '0;
        end
    end

    assign o_drawn      = r_o_drawn;
    assign o_inside_res = r_o_inside;
    assign o_obstacle   = r_o_obst;
    assign o_cell_col   = r_o_col;
    assign o_cell_row   = r_o_row;

    assign o_sts.cmd   = r_cmd;
    assign o_sts.empty = !r_drawn;
    assign o_sts.over  = (w_ex + w_ey) > r_rr;
    assign o_sts.last  = (r_cmd == CMD_CIRCLE) ? (r_side && (r_yoff == r_n - N_W'(1)))
                                               : (r_row + RI_W'(1) == r_row_end);

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.row_wr |-> (w_mask != '0))
        else $error("row write with empty mask");

    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.row_wr |-> (w_row_full < LH_W'(GRID_ROWS)))
        else $error("row write outside grid");

    a_xoff_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.x_dec |-> (r_xoff != '0))
        else $error("circle column offset wraps");

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr_grid |=> (r_row_vld == '0))
        else $error("clear left valid rows");
endmodule

[rtl/occupancy_grid_obstacle_painter.sv]
// Channel  Direction  Handshake              Word
// -------  ---------  ---------------------  -------------------------------------
// cmd in   in         i_valid / o_stall      i_cmd, i_pos_x/y, i_size_w/h, i_radius
// result   out        o_valid / i_stall      o_drawn, o_inside_res, o_obstacle,
//                                            o_cell_col, o_cell_row
// config   in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One command at a time. Every command passes through setup (latch, two
// padding stages, cell ranges) before it acts. Clear and skipped or unknown
// commands then answer at once; a query first reads the grid. Border and
// rectangle read, then OR-write, the 128-bit row word for each painted row,
// through the single write port of the grid RAM. A circle takes, for each
// row offset, two rows, each with an edge check, read and write, plus one
// more edge check per column step along its edge.
// Reset clears per-row valid bits at once, so there is no clearing pass;
// clear does the same. The result word is held while i_stall is high, and
// the next command is taken once it has gone out. Config is always ready.
module occupancy_grid_obstacle_painter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ogp_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ogp_pkg::MM_W-1:0]       i_pos_x,
    input  logic [ogp_pkg::MM_W-1:0]       i_pos_y,
    input  logic [ogp_pkg::MM_W-1:0]       i_size_w,
    input  logic [ogp_pkg::MM_W-1:0]       i_size_h,
    input  logic [ogp_pkg::RAD_W-1:0]      i_radius,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_drawn,
    output logic                           o_inside_res,
    output logic                           o_obstacle,
    output logic [ogp_pkg::COL_W-1:0]      o_cell_col,
    output logic [ogp_pkg::ROW_W-1:0]      o_cell_row,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ogp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ogp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ogp_pkg::*;

    t_dp_cmd w_ctl;   // controller -> datapath strobes
    t_dp_sts w_sts;   // datapath -> controller flags

    // user changes registers only while idle (not enforced); no back-pressure
    assign o_cfg_ready = 1'b1;

    ogp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    ogp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_size_w     (i_size_w),
        .i_size_h     (i_size_h),
        .i_radius     (i_radius),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .o_drawn      (o_drawn),
        .o_inside_res (o_inside_res),
        .o_obstacle   (o_obstacle),
        .o_cell_col   (o_cell_col),
        .o_cell_row   (o_cell_row)
    );
endmodule

[tb/occupancy_grid_obstacle_painter_tb.sv]
`timescale 1ns / 1ps

module occupancy_grid_obstacle_painter_tb;
    import ogp_pkg::*;

    // command word as queued for the driver
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [MM_W-1:0]   px;
        logic [MM_W-1:0]   py;
        logic [MM_W-1:0]   sw;
        logic [MM_W-1:0]   sh;
        logic [RAD_W-1:0]  rad;
    } cmd_word_t;

    // result word as predicted
    typedef struct {
        logic             drawn;
        logic             in_grid;
        logic             obst;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } res_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [CMD_W-1:0] i_cmd = '0;
    logic [MM_W-1:0] i_pos_x = '0, i_pos_y = '0, i_size_w = '0, i_size_h = '0;
    logic [RAD_W-1:0] i_radius = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_drawn, o_inside_res, o_obstacle;
    logic [COL_W-1:0] o_cell_col;
    logic [ROW_W-1:0] o_cell_row;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    occupancy_grid_obstacle_painter dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state: grid copy and register copies
    logic        grid_model [GRID_ROWS][GRID_COLS];
    int unsigned pad_mm, area_w_mm, area_h_mm;

    cmd_word_t   cmd_q[$];
    res_word_t   res_q[$];
    int          errors = 0;
    int          fed = 0;          // words accepted by the DUT
    int          hold_at = 0;      // fed count at which the sender pauses
    bit          hold_send = 1'b0; // sender pause request
    bit          in_acc = 1'b0;    // command word taken at the last rising edge

    function automatic void grid_clear();
        foreach (grid_model[r, c]) grid_model[r][c] = 1'b0;
    endfunction

    // one axis of the rectangle padding
    function automatic void pad_axis(inout int unsigned c, inout int unsigned s,
                                     input int unsigned lim);
        if (c > pad_mm) begin
            c = c - pad_mm;
            s = s + pad_mm;
        end else begin
            c = 0;
        end
        if (c + s + pad_mm < lim) s = s + pad_mm;
        else s = (lim > c) ? lim - c : 0;
    endfunction

    function automatic int unsigned mm_cells(int unsigned mm);
        return (2 * mm + CELL_SIZE) / (2 * CELL_SIZE);
    endfunction

    function automatic res_word_t predict_paint(cmd_word_t w);
        res_word_t   r;
        int unsigned px, py, sw, sh, c0, r0, c1, r1, bw, bc, br;
        int          rr, x0, y0, dx, dy, m, q, n;
        longint      rsq, ex, ey;
        r = '{default: '0};
        case (w.cmd)
            CMD_CLEAR: begin
                grid_clear();
                r.drawn = 1'b1;
            end
            CMD_BORDER: begin
                bw = pad_mm / CELL_SIZE;
                bc = (bw > GRID_COLS) ? GRID_COLS : bw;
                br = (bw > GRID_ROWS) ? GRID_ROWS : bw;
                for (int k = 0; k < GRID_ROWS; k++)
                    for (int l = 0; l < bc; l++) begin
                        grid_model[k][l] = 1'b1;
                        grid_model[k][GRID_COLS-1-l] = 1'b1;
                    end
                for (int k = 0; k < GRID_COLS; k++)
                    for (int l = 0; l < br; l++) begin
                        grid_model[l][k] = 1'b1;
                        grid_model[GRID_ROWS-1-l][k] = 1'b1;
                    end
                r.drawn = (bw > 0);
            end
            CMD_RECT: begin
                px = w.px; py = w.py; sw = w.sw; sh = w.sh;
                pad_axis(px, sw, area_w_mm);
                pad_axis(py, sh, area_h_mm);
                c0 = mm_cells(px);
                r0 = mm_cells(py);
                c1 = c0 + mm_cells(sw);
                r1 = r0 + mm_cells(sh);
                if (c1 > GRID_COLS) c1 = GRID_COLS;
                if (r1 > GRID_ROWS) r1 = GRID_ROWS;
                for (int unsigned i = r0; i < r1; i++)
                    for (int unsigned j = c0; j < c1; j++) begin
                        grid_model[i][j] = 1'b1;
                        r.drawn = 1'b1;
                    end
            end
            CMD_CIRCLE: begin
                rr = int'(w.rad) + int'(pad_mm);
                x0 = w.px / CELL_SIZE; y0 = w.py / CELL_SIZE;
                dx = w.px % CELL_SIZE; dy = w.py % CELL_SIZE;
                m = dx;
                if (dy > m) m = dy;
                if (CELL_SIZE - dx > m) m = CELL_SIZE - dx;
                if (CELL_SIZE - dy > m) m = CELL_SIZE - dy;
                q = rr - m;
                n = 1 + (q >= 0 ? q / CELL_SIZE : -((-q) / CELL_SIZE));
                if (n > 0 && !(x0 < n - 1 || x0 > GRID_COLS - n ||
                               y0 < n - 1 || y0 > GRID_ROWS - n)) begin
                    rsq = longint'(2 * n - 1) * CELL_SIZE;
                    rsq = rsq * rsq;
                    for (int x = 0; x < n; x++) begin
                        ex = longint'(2 * x) * CELL_SIZE;
                        ex = ex * ex;
                        for (int y = 0; y < n; y++) begin
                            ey = longint'(2 * y + 1) * CELL_SIZE;
                            if (ey * ey + ex > rsq) break;
                            grid_model[y0+y][x0+x] = 1'b1;
                            grid_model[y0+y][x0-x] = 1'b1;
                            grid_model[y0-y][x0+x] = 1'b1;
                            grid_model[y0-y][x0-x] = 1'b1;
                        end
                    end
                    r.drawn = 1'b1;
                end
            end
            CMD_QUERY: begin
                c0 = w.px / CELL_SIZE;
                r0 = w.py / CELL_SIZE;
                if (r0 < GRID_ROWS && c0 < GRID_COLS) begin
                    r.in_grid = 1'b1;
                    r.obst = grid_model[r0][c0];
                    r.col = c0[COL_W-1:0];
                    r.row = r0[ROW_W-1:0];
                end
            end
            default: ;  // unknown commands: all zero
        endcase
        return r;
    endfunction

    // input accept: predict at the edge that takes the word
    always @(posedge i_clk) begin
        in_acc = i_rst_n && i_valid && !o_stall;
        if (in_acc) begin
            res_q.push_back(predict_paint(cmd_q.pop_front()));
            fed++;
        end
    end

    // driver: one word at a time, with a random gap after each accepted word
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc) send_gap = $urandom_range(0, 4);
            if (i_valid && !in_acc) begin
                // stalled: hold the payload
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (cmd_q.size() > 0 && !hold_send) begin
                i_valid  <= 1'b1;
                i_cmd    <= cmd_q[0].cmd;
                i_pos_x  <= cmd_q[0].px;
                i_pos_y  <= cmd_q[0].py;
                i_size_w <= cmd_q[0].sw;
                i_size_h <= cmd_q[0].sh;
                i_radius <= cmd_q[0].rad;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: holds off each result word for a fresh random count
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor
    res_word_t exp_w;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            recv_gap = $urandom_range(0, 4);
            if (res_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word");
            end else begin
                exp_w = res_q.pop_front();
                if (o_drawn !== exp_w.drawn || o_inside_res !== exp_w.in_grid ||
                    o_obstacle !== exp_w.obst || o_cell_col !== exp_w.col ||
                    o_cell_row !== exp_w.row) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp d%0b i%0b o%0b c%0d r%0d, got d%0b i%0b o%0b c%0d r%0d",
                            exp_w.drawn, exp_w.in_grid, exp_w.obst, exp_w.col, exp_w.row,
                            o_drawn, o_inside_res, o_obstacle, o_cell_col, o_cell_row);
                end
            end
        end
    end

    task automatic push_cmd(logic [CMD_W-1:0] c, int px, int py, int sw, int sh, int rad);
        cmd_word_t w;
        w.cmd = c; w.px = px; w.py = py; w.sw = sw; w.sh = sh; w.rad = rad;
        cmd_q.push_back(w);
    endtask

    // wait until everything queued has been answered, then some slack
    task automatic drain();
        while (cmd_q.size() > 0 || i_valid || res_q.size() > 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROBOT_RADIUS: pad_mm    = val & 10'h3FF;
            CFG_AREA_WIDTH:   area_w_mm = val & 16'hFFFF;
            default:          area_h_mm = val & 16'hFFFF;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random word, mostly in the playing area so the grid fills up
    task automatic push_random();
        int c, px, py;
        c = $urandom_range(0, 99);
        if (c < 3) c = CMD_CLEAR;
        else if (c < 6) c = CMD_BORDER;
        else if (c < 30) c = CMD_RECT;
        else if (c < 50) c = CMD_CIRCLE;
        else if (c < 97) c = CMD_QUERY;
        else c = $urandom_range(5, 7);
        if ($urandom_range(0, 9) == 0) begin
            px = $urandom_range(0, 65535); py = $urandom_range(0, 65535);
        end else begin
            px = $urandom_range(0, 4200); py = $urandom_range(0, 2100);
        end
        push_cmd(c, px, py,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 600),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 600),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 300));
    endtask

    initial begin
        grid_clear();
        pad_mm = 150; area_w_mm = 3000; area_h_mm = 2000;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every command, field extremes, corner cases
        push_cmd(CMD_QUERY, 0, 0, 0, 0, 0);
        push_cmd(CMD_BORDER, 0, 0, 0, 0, 0);
        push_cmd(CMD_QUERY, 0, 1000, 0, 0, 0);
        push_cmd(CMD_QUERY, 4095, 2047, 0, 0, 0);
        push_cmd(CMD_QUERY, 65535, 65535, 0, 0, 0);   // outside the grid
        push_cmd(CMD_CLEAR, 65535, 65535, 65535, 65535, 4095);
        push_cmd(CMD_RECT, 500, 500, 100, 100, 0);
        push_cmd(CMD_QUERY, 520, 520, 0, 0, 0);
        push_cmd(CMD_RECT, 0, 0, 65535, 65535, 0);
        push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
        push_cmd(CMD_RECT, 65535, 65535, 10, 10, 0);  // beyond the grid
        push_cmd(CMD_CIRCLE, 2000, 1000, 0, 0, 100);
        push_cmd(CMD_QUERY, 2000, 1000, 0, 0, 0);
        push_cmd(CMD_CIRCLE, 16, 16, 0, 0, 4095);     // too large
        push_cmd(CMD_CIRCLE, 65535, 65535, 0, 0, 0);
        push_cmd(5, 100, 100, 1, 1, 1);
        push_cmd(7, 65535, 0, 65535, 0, 4095);
        drain();

        // extremes of the registers: zero padding, zero area
        write_reg(CFG_ROBOT_RADIUS, 0);
        write_reg(CFG_AREA_WIDTH, 0);
        write_reg(CFG_AREA_HEIGHT, 0);
        push_cmd(CMD_BORDER, 0, 0, 0, 0, 0);          // zero width border
        push_cmd(CMD_RECT, 100, 100, 100, 100, 0);
        push_cmd(CMD_CIRCLE, 1000, 1000, 0, 0, 0);    // centre cell only
        push_cmd(CMD_QUERY, 1000, 1000, 0, 0, 0);
        drain();

        write_reg(CFG_ROBOT_RADIUS, 1023);
        write_reg(CFG_AREA_WIDTH, 65535);
        write_reg(CFG_AREA_HEIGHT, 65535);
        push_cmd(CMD_BORDER, 0, 0, 0, 0, 0);          // widest border: 31 cells each side
        push_cmd(CMD_QUERY, 2000, 1000, 0, 0, 0);
        push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
        push_cmd(CMD_RECT, 3000, 1000, 50, 50, 0);
        drain();

        // random phases; each after the first gets fresh register settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_ROBOT_RADIUS, (ph == 7) ? 0 : $urandom_range(0, 1023) % 400);
                write_reg(CFG_AREA_WIDTH, (ph == 5) ? 65535 : $urandom_range(0, 4500));
                write_reg(CFG_AREA_HEIGHT, (ph == 6) ? 0 : $urandom_range(0, 2500));
            end
            for (int k = 0; k < 120; k++) push_random();
            if (ph == 3) begin
                // sender holds off mid-phase until all results are in, then resumes
                hold_at = fed + 40;
                while (fed < hold_at) @(posedge i_clk);
                hold_send = 1'b1;
                while (res_q.size() > 0 || i_valid) @(posedge i_clk);
                repeat (20) @(posedge i_clk);
                hold_send = 1'b0;
            end
            drain();
        end

        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[occupancy_grid_obstacle_painter.f]
rtl/ogp_pkg.sv
rtl/ogp_ram.sv
rtl/ogp_ctrl.sv
rtl/ogp_dp.sv
rtl/occupancy_grid_obstacle_painter.sv
tb/occupancy_grid_obstacle_painter_tb.sv
